// File: rtl/bat_pkg.sv
// Shared types and constants for the breakpoint address table.
package bat_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned EntCntW = 5;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TOGGLE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] address;
  } bat_req_t;

  typedef struct packed {
    logic               hit;
    logic               changed;
    logic [EntCntW-1:0] entry_count;
  } bat_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic commit;
  } bat_cmd_t;

endpackage

// File: rtl/bat_ctrl.sv
// Sequencing controller: accept, execute and hand-off of one word at a time.
module bat_ctrl import bat_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bat_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   commit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign commit      = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.commit = commit;
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          // Hold until the output register is free.
          if (commit) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/bat_datapath.sv
// Entry registers, parallel comparators, compaction shift and result register.
module bat_datapath import bat_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bat_cmd_t cmd_i,
  input  bat_req_t req_i,
  output bat_rsp_t rsp_o
);

  bat_req_t         req_q;
  logic [AddrW-1:0] addr_q [Depth];
  logic [Depth-1:0] en_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  count_d;
  bat_rsp_t         rsp_q;

  logic [Depth-1:0] live;
  logic [Depth-1:0] match;
  logic [IdxW-1:0]  first_idx;
  logic             hit;
  logic             any_match;
  logic             full;
  logic             do_add;
  logic             do_rem;
  logic             add_ok;
  logic             rem_ok;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      live[i]  = (CntW'(i) < count_q);
      match[i] = live[i] && (addr_q[i] == req_q.address);
    end
  end

  // Lowest matching slot.
  always_comb begin
    first_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = IdxW'(i);
      end
    end
  end

  assign hit       = |(match & en_q);
  assign any_match = |match;
  assign full      = (count_q == CntW'(Depth));

  always_comb begin
    do_add = 1'b0;
    do_rem = 1'b0;
    case (req_type_e'(req_q.req_type))
      REQ_ADD:    do_add = 1'b1;
      REQ_REMOVE: do_rem = 1'b1;
      REQ_TOGGLE: begin
        do_rem = hit;
        do_add = !hit;
      end
      REQ_QUERY:  ;
      default:    ;
    endcase
  end

  assign add_ok = do_add && !full;
  assign rem_ok = do_rem && any_match;

  always_comb begin
    count_d = count_q;
    if (add_ok) begin
      count_d = count_q + CntW'(1);
    end else if (rem_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.commit) begin
      rsp_q.hit         <= hit;
      rsp_q.changed     <= add_ok || rem_ok;
      rsp_q.entry_count <= EntCntW'(count_d);
      // Shift later entries down over the removed slot.
      for (int j = 0; j < Depth - 1; j++) begin
        if (rem_ok && (IdxW'(j) >= first_idx)) begin
          addr_q[j] <= addr_q[j+1];
          en_q[j]   <= en_q[j+1];
        end
      end
      // Append at the first free slot.
      for (int j = 0; j < Depth; j++) begin
        if (add_ok && (CntW'(j) == count_q)) begin
          addr_q[j] <= req_q.address;
          en_q[j]   <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: rtl/breakpoint_address_table.sv
// Top level of the breakpoint address table: controller plus datapath.
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_req_i) carries one request
//   word: a request type (add, remove, toggle, query) and a 32-bit address
//   or program counter.
//   Output channel (out_valid_o / out_ready_i / out_rsp_o) returns one word
//   per request: hit (an enabled entry matched before the request),
//   changed (the table was modified) and the entry count afterwards.
// Timing:
//   A request is taken while the controller is idle and executed in the
//   execute state, where all slots are compared in parallel and the add,
//   or the compaction shift of a remove, is written. The response is
//   registered when that execution commits. No new request is accepted
//   until the current one has been executed, as set by the accept/execute
//   sequence of the controller.
// Stall:
//   The output register holds its word until taken. A new request is still
//   accepted while it waits; its execution then holds until the output
//   register is free, and no further request is taken meanwhile.
// Reset:
//   rst_ni clears the entry count and the handshake state; slot contents
//   are only read below the count and need no clearing.
module breakpoint_address_table import bat_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bat_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bat_rsp_t out_rsp_o
);

  bat_cmd_t cmd;

  // Sequence accept and commit.
  bat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold the table and compute each response.
  bat_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule
